>>> sv/lpbe_pkg.sv
// shared types, codes and constants of the led pixel buffer engine
`default_nettype none

package lpbe_pkg;

    localparam int DEFAULT_MAX_PIXELS = 256;
    localparam int PIX_W              = 9;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QPTR_W             = 1;
    localparam int APB_ADDR_W         = 5;

    localparam logic [1:0] CMD_SET  = 2'd0;
    localparam logic [1:0] CMD_FILL = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_XMIT = 2'd3;

    localparam logic [2:0] REG_STRIP_LEN   = 3'd0;
    localparam logic [2:0] REG_FOUR_BYTES  = 3'd1;
    localparam logic [2:0] REG_LUMINANCE   = 3'd2;
    localparam logic [2:0] REG_WHITE_CHAN  = 3'd3;
    localparam logic [2:0] REG_OFFSETS     = 3'd4;
    localparam logic [2:0] REG_BRIGHTNESS  = 3'd5;

    localparam logic [7:0] RST_OFFSETS   = 8'd228;
    localparam logic [8:0] FULL_SCALE    = 9'd256;
    localparam logic [7:0] BYTE_ONES     = 8'hff;
    localparam logic [7:0] LUM_PREFIX    = 8'he0;
    localparam logic [10:0] THIRD_RECIP  = 11'd683;

    typedef enum logic [1:0] {
        OP_SET,
        OP_FILL,
        OP_READ,
        OP_XMIT
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic [PIX_W-1:0] cnt;
        logic             bpp4;
        logic             lum;
        logic             white_chan;
        logic [7:0]       offsets;
        logic [8:0]       bscale;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic             err;
        logic [PIX_W-1:0] pix;
        logic [1:0]       pos;
        logic             dim;
        logic [31:0]      word;
        logic [3:0]       be;
    } t_work;

    typedef struct packed {
        t_op        op;
        logic       err;
        logic [1:0] pos;
        logic       dim;
    } t_stage;

    typedef struct packed {
        logic [7:0] rd_red;
        logic [7:0] rd_green;
        logic [7:0] rd_blue;
        logic [7:0] rd_white;
        logic [7:0] tx_byte;
        logic       err;
    } t_result;

endpackage

`default_nettype wire

>>> sv/led_pixel_buffer_engine_top.sv
// top level of the led pixel buffer engine: register port, front end, queue, pixel engine
//
// commands enter on the input channel (i_in_valid / o_in_ready), one result per
// command leaves on the output channel (o_out_valid / i_out_ready)
// set, read pixel and read transmit byte: one command per cycle sustained while
// the receiver takes results, each passing the queue, read stage and result register
// fill all: one pixel written per cycle, set by the single write port of the
// pixel memory; registers are to be written over the apb port only while no
// command is in flight, which the block itself does not enforce
// after reset the pixel memory is cleared one entry per cycle; o_in_ready stays
// low during that pass
// when the receiver stalls, the result register holds, the engine stops at
// the next command and the two-entry queue then backs up to o_in_ready
`default_nettype none

module led_pixel_buffer_engine_top
    import lpbe_pkg::*;
#(
    parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  [1:0]            i_command,
    input  wire  [7:0]            i_pixel_index,
    input  wire  [9:0]            i_byte_address,
    input  wire  [7:0]            i_red,
    input  wire  [7:0]            i_green,
    input  wire  [7:0]            i_blue,
    input  wire  [7:0]            i_white,
    input  wire                   i_white_given,
    input  wire                   i_packed_form,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [7:0]            o_read_red,
    output logic [7:0]            o_read_green,
    output logic [7:0]            o_read_blue,
    output logic [7:0]            o_read_white,
    output logic [7:0]            o_transmit_byte,
    output logic                  o_range_error
);

    logic [8:0] r_strip_len;
    logic       r_four_bytes;
    logic       r_luminance;
    logic       r_white_chan;
    logic [7:0] r_offsets;
    logic [8:0] r_brightness;

    logic       wr_en;
    logic [2:0] reg_idx;
    t_cfg       cfg;
    logic       busy;
    logic       q_full;
    logic       q_valid;
    logic       push;
    logic       pop;
    t_work      front_item;
    t_work      head_item;
    t_result    result;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip_len   <= '0;
            r_four_bytes  <= 1'b0;
            r_luminance   <= 1'b0;
            r_white_chan  <= 1'b0;
            r_offsets     <= RST_OFFSETS;
            r_brightness  <= FULL_SCALE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STRIP_LEN:   r_strip_len   <= pwdata[8:0];
                REG_FOUR_BYTES:  r_four_bytes  <= pwdata[0];
                REG_LUMINANCE:   r_luminance   <= pwdata[0];
                REG_WHITE_CHAN:  r_white_chan  <= pwdata[0];
                REG_OFFSETS:     r_offsets     <= pwdata[7:0];
                REG_BRIGHTNESS:  r_brightness  <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STRIP_LEN:   prdata = 32'(r_strip_len);
            REG_FOUR_BYTES:  prdata = 32'(r_four_bytes);
            REG_LUMINANCE:   prdata = 32'(r_luminance);
            REG_WHITE_CHAN:  prdata = 32'(r_white_chan);
            REG_OFFSETS:     prdata = 32'(r_offsets);
            REG_BRIGHTNESS:  prdata = 32'(r_brightness);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        cfg.cnt        = (32'(r_strip_len) > 32'(MAX_PIXELS)) ? 9'(MAX_PIXELS)
                                                              : r_strip_len;
        cfg.bpp4       = r_four_bytes || r_luminance;
        cfg.lum        = r_luminance;
        cfg.white_chan = r_white_chan;
        cfg.offsets    = r_offsets;
        cfg.bscale     = (r_brightness > FULL_SCALE) ? FULL_SCALE : r_brightness;
    end

    lpbe_front u_front (
        .i_cfg          (cfg),
        .i_busy         (busy),
        .i_q_full       (q_full),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_pixel_index  (i_pixel_index),
        .i_byte_address (i_byte_address),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_white        (i_white),
        .i_white_given  (i_white_given),
        .i_packed_form  (i_packed_form),
        .o_push         (push),
        .o_item         (front_item)
    );

    lpbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    lpbe_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .o_busy      (busy),
        .i_q_valid   (q_valid),
        .i_q_item    (head_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_read_red      = result.rd_red;
    assign o_read_green    = result.rd_green;
    assign o_read_blue     = result.rd_blue;
    assign o_read_white    = result.rd_white;
    assign o_transmit_byte = result.tx_byte;
    assign o_range_error   = result.err;

endmodule

`default_nettype wire

>>> sv/lpbe_front.sv
// command front end: color conversion, byte placement, range check, address split
`default_nettype none

module lpbe_front
    import lpbe_pkg::*;
(
    input  wire  t_cfg        i_cfg,
    input  wire               i_busy,
    input  wire               i_q_full,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire  [1:0]        i_command,
    input  wire  [7:0]        i_pixel_index,
    input  wire  [9:0]        i_byte_address,
    input  wire  [7:0]        i_red,
    input  wire  [7:0]        i_green,
    input  wire  [7:0]        i_blue,
    input  wire  [7:0]        i_white,
    input  wire               i_white_given,
    input  wire               i_packed_form,
    output logic              o_push,
    output t_work             o_item
);

    logic [7:0]  c0, c1, c2, c3, c3_raw;
    logic [1:0]  off0, off1, off2, off3;
    logic [31:0] word;
    logic [3:0]  be;
    logic [20:0] prod3;
    logic [9:0]  p3;
    logic [11:0] rem3;
    logic [10:0] limit;
    logic        idx_err;
    logic        addr_err;
    logic [PIX_W-1:0] xmit_pix;
    logic [1:0]  xmit_pos;

    assign off0 = i_cfg.offsets[1:0];
    assign off1 = i_cfg.offsets[3:2];
    assign off2 = i_cfg.offsets[5:4];
    assign off3 = i_cfg.offsets[7:6];

    // white conversion and default white
    always_comb begin
        c0     = i_red;
        c1     = i_green;
        c2     = i_blue;
        c3_raw = i_cfg.lum ? BYTE_ONES : 8'd0;
        if (i_packed_form) begin
            if (!i_cfg.lum && i_cfg.bpp4 && i_cfg.white_chan &&
                i_red == i_green && i_red == i_blue) begin
                c3_raw = i_red;
                c0     = 8'd0;
                c1     = 8'd0;
                c2     = 8'd0;
            end
        end else if (i_white_given) begin
            c3_raw = i_white;
        end
        c3 = i_cfg.lum ? (LUM_PREFIX | {3'd0, c3_raw[7:3]}) : c3_raw;
    end

    // byte placement, on colliding offsets blue wins over green, green over red, red over white
    always_comb begin
        word = '0;
        be   = '0;
        for (int k = 0; k < 4; k++) begin
            if (i_cfg.bpp4 && off3 == 2'(k)) begin
                word[8*k +: 8] = c3;
                be[k]          = 1'b1;
            end
            if (off0 == 2'(k)) begin
                word[8*k +: 8] = c0;
                be[k]          = 1'b1;
            end
            if (off1 == 2'(k)) begin
                word[8*k +: 8] = c1;
                be[k]          = 1'b1;
            end
            if (off2 == 2'(k)) begin
                word[8*k +: 8] = c2;
                be[k]          = 1'b1;
            end
        end
    end

    // transmit address split into pixel and byte position
    assign prod3    = 21'(i_byte_address) * 21'(THIRD_RECIP);
    assign p3       = prod3[20:11];
    assign rem3     = 12'(i_byte_address) - 12'(p3) * 12'd3;
    assign limit    = i_cfg.bpp4 ? {i_cfg.cnt, 2'b00}
                                 : (11'(i_cfg.cnt) + {1'b0, i_cfg.cnt, 1'b0});
    assign addr_err = 11'(i_byte_address) >= limit;
    assign idx_err  = 9'(i_pixel_index) >= i_cfg.cnt;
    assign xmit_pix = i_cfg.bpp4 ? 9'(i_byte_address[9:2]) : p3[8:0];
    assign xmit_pos = i_cfg.bpp4 ? i_byte_address[1:0] : rem3[1:0];

    always_comb begin
        o_item.word = word;
        o_item.be   = be;
        o_item.pix  = 9'(i_pixel_index);
        o_item.pos  = 2'd0;
        o_item.dim  = 1'b1;
        o_item.err  = 1'b0;
        o_item.op   = OP_SET;
        unique case (i_command)
            CMD_SET: begin
                o_item.op  = OP_SET;
                o_item.err = idx_err;
            end
            CMD_FILL: begin
                o_item.op = OP_FILL;
            end
            CMD_READ: begin
                o_item.op  = OP_READ;
                o_item.err = idx_err;
            end
            CMD_XMIT: begin
                o_item.op  = OP_XMIT;
                o_item.err = addr_err;
                o_item.pix = xmit_pix;
                o_item.pos = xmit_pos;
                o_item.dim = !(i_cfg.lum && xmit_pos == off3);
            end
            default: begin
                o_item.op = OP_SET;
            end
        endcase
    end

    assign o_in_ready = !i_q_full && !i_busy;
    assign o_push     = i_in_valid && o_in_ready;

endmodule

`default_nettype wire

>>> sv/lpbe_queue.sv
// short command queue between front end and pixel engine
`default_nettype none

module lpbe_queue
    import lpbe_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    input  wire  t_work i_item,
    output logic        o_full,
    input  wire         i_pop,
    output logic        o_valid,
    output t_work       o_item
);

    t_work             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_level;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QPTR_W:0]   n_level;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_level  = r_level + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = r_level == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_level != '0;
    assign o_item  = r_slot[r_rd_ptr];

endmodule

`default_nettype wire

>>> sv/lpbe_back.sv
// pixel engine: pixel memory, clearing pass, fill sweep, read-out and scaling
`default_nettype none

module lpbe_back
    import lpbe_pkg::*;
#(
    parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire  t_cfg   i_cfg,
    output logic         o_busy,
    input  wire          i_q_valid,
    input  wire  t_work  i_q_item,
    output logic         o_pop,
    output logic         o_out_valid,
    input  wire          i_out_ready,
    output t_result      o_result
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(MAX_PIXELS - 1);

    logic [32:0]      r_mem [MAX_PIXELS];
    logic [32:0]      r_rd;
    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [PIX_W-1:0] r_fill_idx, n_fill_idx;
    logic             r_b_valid;
    t_stage           r_b;
    logic             r_out_valid;
    t_result          r_out;

    logic        mem_we;
    logic        mem_re;
    logic [4:0]  mem_be;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic [32:0] mem_wd;
    logic        b_load;
    logic        b_move;
    logic        can_issue;
    t_stage      b_item;
    t_result     res;
    logic [7:0]  tx_raw;
    logic [16:0] tx_prod;

    function automatic logic [7:0] byte_at(input logic [32:0] data, input logic [1:0] pos,
                                           input logic lum, input logic [1:0] off3);
        logic [7:0] v;
        v = data[8*pos +: 8];
        if (lum && !data[32] && pos == off3) begin
            v = BYTE_ONES;
        end
        return v;
    endfunction

    assign b_move    = r_b_valid && (!r_out_valid || i_out_ready);
    assign can_issue = !r_b_valid || b_move;

    always_comb begin
        b_item.op  = i_q_item.op;
        b_item.err = i_q_item.err;
        b_item.pos = i_q_item.pos;
        b_item.dim = i_q_item.dim;
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_fill_idx = r_fill_idx;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_be     = {1'b1, i_q_item.be};
        mem_wa     = AW'(i_q_item.pix);
        mem_ra     = AW'(i_q_item.pix);
        mem_wd     = {1'b1, i_q_item.word};
        o_pop      = 1'b0;
        b_load     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_be     = '1;
                mem_wd     = '0;
                mem_wa     = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ENTRY) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_q_valid && can_issue) begin
                    unique case (i_q_item.op)
                        OP_SET: begin
                            mem_we = !i_q_item.err;
                            o_pop  = 1'b1;
                            b_load = 1'b1;
                        end
                        OP_FILL: begin
                            if (i_cfg.cnt == '0) begin
                                o_pop  = 1'b1;
                                b_load = 1'b1;
                            end else begin
                                n_state    = ST_FILL;
                                n_fill_idx = '0;
                            end
                        end
                        OP_READ, OP_XMIT: begin
                            mem_re = !i_q_item.err;
                            o_pop  = 1'b1;
                            b_load = 1'b1;
                        end
                        default: begin
                            o_pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_fill_idx);
                if (r_fill_idx == i_cfg.cnt - 1'b1) begin
                    if (can_issue) begin
                        o_pop   = 1'b1;
                        b_load  = 1'b1;
                        n_state = ST_RUN;
                    end
                end else begin
                    n_fill_idx = r_fill_idx + 1'b1;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_fill_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_fill_idx <= n_fill_idx;
        end
    end

    // pixel memory with byte lanes and a written flag lane
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int k = 0; k < 4; k++) begin
                if (mem_be[k]) begin
                    r_mem[mem_wa][8*k +: 8] <= mem_wd[8*k +: 8];
                end
            end
            if (mem_be[4]) begin
                r_mem[mem_wa][32] <= mem_wd[32];
            end
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    // read-out and brightness scaling
    assign tx_raw  = byte_at(r_rd, r_b.pos, i_cfg.lum, i_cfg.offsets[7:6]);
    assign tx_prod = 17'(tx_raw) * 17'(i_cfg.bscale);

    always_comb begin
        res     = '0;
        res.err = r_b.err;
        if (!r_b.err) begin
            unique case (r_b.op)
                OP_READ: begin
                    res.rd_red   = byte_at(r_rd, i_cfg.offsets[1:0], i_cfg.lum,
                                           i_cfg.offsets[7:6]);
                    res.rd_green = byte_at(r_rd, i_cfg.offsets[3:2], i_cfg.lum,
                                           i_cfg.offsets[7:6]);
                    res.rd_blue  = byte_at(r_rd, i_cfg.offsets[5:4], i_cfg.lum,
                                           i_cfg.offsets[7:6]);
                    if (i_cfg.bpp4) begin
                        res.rd_white = byte_at(r_rd, i_cfg.offsets[7:6], i_cfg.lum,
                                               i_cfg.offsets[7:6]);
                        if (i_cfg.lum) begin
                            res.rd_white = {3'd0, res.rd_white[4:0]};
                        end
                    end
                end
                OP_XMIT: begin
                    res.tx_byte = r_b.dim ? tx_prod[15:8] : tx_raw;
                end
                OP_SET, OP_FILL: begin
                    res.tx_byte = 8'd0;
                end
                default: begin
                    res.tx_byte = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (b_load) begin
                r_b_valid <= 1'b1;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b <= b_item;
        end
        if (b_move) begin
            r_out <= res;
        end
    end

    assign o_busy      = r_state == ST_CLEAR;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire
